/* rtl/tmh_pkg.sv */
// Package for the timer min-heap scheduler: widths, command and result codes.
// No dependencies.
package tmh_pkg;
    localparam int HEAP_DEPTH = 32;
    localparam int TIME_BITS  = 48;
    localparam int IDX_BITS   = 5;
    localparam int CNT_BITS   = 6;
    localparam int TAG_BITS   = 5;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_POLL   = 2'd2;

    localparam logic [1:0] KIND_FIRED   = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_OK      = 2'd2;
    localparam logic [1:0] KIND_REJECT  = 2'd3;

    typedef struct packed {
        logic [1:0]           command;
        logic [TIME_BITS-1:0] expiry_time;
        logic [TAG_BITS-1:0]  timer_tag;
        logic [TIME_BITS-1:0] now_time;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [TAG_BITS-1:0]  fired_tag;
        logic [TIME_BITS-1:0] next_expiry;
        logic                 pending;
        logic [CNT_BITS-1:0]  entry_total;
        logic                 last;
    } res_word_t;
endpackage

/* rtl/tmh_cmd_if.sv */
// Valid/ready channel interfaces for command and result words.
// Depends on tmh_pkg.
interface tmh_cmd_if import tmh_pkg::*; ();
    logic      valid;
    logic      ready;
    cmd_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tmh_res_if import tmh_pkg::*; ();
    logic      valid;
    logic      ready;
    res_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/timer_min_heap_scheduler.sv */
// Timer min-heap scheduler top level: sequencer, heap storage, result register.
// Depends on tmh_pkg and the channel interfaces in tmh_cmd_if.sv.
//
//  channel | dir | fields
//  cmd     | in  | command, expiry_time, timer_tag, now_time
//  res     | out | kind, fired_tag, next_expiry, pending, entry_total, last
//
// One item is handled at a time; cmd.ready is high only in idle.
// Insert: per heap level of sift-up, one parent read and one compare/move.
// Cancel: an alive-bit sweep that reads each stored entry in turn.
// Poll: per pop a root check and last-entry read, then per level of sift-down
// two child reads, compare and move, then the emit step.
// Every result word waits in the output register; the sequencer stalls there.
// Reset clears the count, live bits and control state; heap storage is not
// cleared (slots at or beyond the count are never used).
module timer_min_heap_scheduler
    import tmh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tmh_cmd_if.sink   cmd,
    tmh_res_if.source res
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UPRD   = 4'd1;
    localparam logic [3:0] S_UPCMP  = 4'd2;
    localparam logic [3:0] S_CANCEL = 4'd3;
    localparam logic [3:0] S_ROOT   = 4'd4;
    localparam logic [3:0] S_ROOTCK = 4'd5;
    localparam logic [3:0] S_LASTRD = 4'd6;
    localparam logic [3:0] S_DNRD   = 4'd7;
    localparam logic [3:0] S_DNCMP  = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;
    localparam logic [3:0] S_WAIT   = 4'd10;
    localparam logic [3:0] S_DNRD2  = 4'd11;

    // heap storage: expiry, tag, alive packed per slot
    localparam int EW = TIME_BITS + TAG_BITS + 1;
    logic [EW-1:0] mem [HEAP_DEPTH];
    logic [EW-1:0] rd_reg;
    logic [IDX_BITS-1:0] rd_addr;
    logic          we;
    logic [IDX_BITS-1:0] wa;
    logic [EW-1:0] wd;

    logic [3:0]           state_reg, state_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [HEAP_DEPTH-1:0] live_reg, live_next;
    logic [IDX_BITS-1:0]  pos_reg, pos_next;
    logic [EW-1:0]        item_reg, item_next;   // entry being placed
    logic [EW-1:0]        best_reg, best_next;
    logic [IDX_BITS-1:0]  pick_reg, pick_next;
    logic                 side_reg, side_next;   // sift-down: 0 left read, 1 right read; cancel: read pending
    logic [TIME_BITS-1:0] root_reg, root_next;   // cached root expiry
    logic [EW-1:0]        top_reg, top_next;     // popped root
    cmd_word_t            in_reg, in_next;
    logic                 ov_reg, ov_next;
    res_word_t            out_reg, out_next;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_reg <= mem[rd_addr];
    end

    function automatic logic [TIME_BITS-1:0] ex_of(logic [EW-1:0] e);
        return e[EW-1 -: TIME_BITS];
    endfunction

    assign cmd.ready = (state_reg == S_IDLE) && !ov_reg;
    assign res.valid = ov_reg;
    assign res.data  = out_reg;

    logic [IDX_BITS:0] lidx;
    always_comb
    begin
        state_next = state_reg; count_next = count_reg; live_next = live_reg;
        pos_next = pos_reg; item_next = item_reg; best_next = best_reg;
        pick_next = pick_reg; side_next = side_reg; root_next = root_reg;
        top_next = top_reg; in_next = in_reg; ov_next = ov_reg;
        out_next = out_reg;
        we = 1'b0; wa = pos_reg; wd = item_reg; rd_addr = '0;
        lidx = {pos_reg, 1'b1};
        if (ov_reg && res.ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid && cmd.ready)
                begin
                    in_next = cmd.data;
                    out_next.fired_tag = '0;
                    out_next.last = 1'b1;
                    unique case (cmd.data.command)
                        CMD_INSERT:
                        begin
                            if (count_reg == CNT_BITS'(HEAP_DEPTH) ||
                                live_reg[cmd.data.timer_tag])
                            begin
                                out_next.kind = KIND_REJECT;
                                state_next = S_WAIT;
                            end
                            else
                            begin
                                live_next[cmd.data.timer_tag] = 1'b1;
                                pos_next = count_reg[IDX_BITS-1:0];
                                item_next = {cmd.data.expiry_time,
                                             cmd.data.timer_tag, 1'b1};
                                count_next = count_reg + 1'b1;
                                out_next.kind = KIND_OK;
                                state_next = S_UPRD;
                            end
                        end
                        CMD_CANCEL:
                        begin
                            out_next.kind = KIND_OK;
                            if (live_reg[cmd.data.timer_tag])
                            begin
                                live_next[cmd.data.timer_tag] = 1'b0;
                                pos_next = '0;
                                side_next = 1'b0;
                                state_next = S_CANCEL;
                            end
                            else
                                state_next = S_WAIT;
                        end
                        CMD_POLL: state_next = S_ROOT;
                        default:
                        begin
                            out_next.kind = KIND_SUMMARY;
                            state_next = S_WAIT;
                        end
                    endcase
                end
            end
            S_UPRD:
            begin
                if (pos_reg == '0)
                begin
                    we = 1'b1; wa = pos_reg; wd = item_reg;
                    root_next = ex_of(item_reg);
                    state_next = S_WAIT;
                end
                else
                begin
                    rd_addr = (pos_reg - 1'b1) >> 1;
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                if (ex_of(rd_reg) > ex_of(item_reg))
                begin
                    we = 1'b1; wa = pos_reg; wd = rd_reg;
                    pos_next = (pos_reg - 1'b1) >> 1;
                    state_next = S_UPRD;
                end
                else
                begin
                    we = 1'b1; wa = pos_reg; wd = item_reg;
                    state_next = S_WAIT;
                end
            end
            S_CANCEL:
            begin
                // read slot pos, next cycle clear alive if tag matches
                if (side_reg && rd_reg[TAG_BITS:1] == in_reg.timer_tag)
                begin
                    we = 1'b1; wa = pick_reg; wd = {rd_reg[EW-1:1], 1'b0};
                end
                if (side_reg && pick_reg == IDX_BITS'(count_reg - 1'b1))
                begin
                    side_next = 1'b0;
                    state_next = S_WAIT;
                end
                else
                begin
                    rd_addr = pos_reg;
                    side_next = 1'b1;
                    pick_next = pos_reg;
                    pos_next = pos_reg + 1'b1;
                end
            end
            S_ROOT:
            begin
                rd_addr = '0;
                state_next = S_ROOTCK;
            end
            S_ROOTCK:
            begin
                if (count_reg != '0 &&
                    (!rd_reg[0] || !(ex_of(rd_reg) > in_reg.now_time)))
                begin
                    top_next = rd_reg;
                    rd_addr = IDX_BITS'(count_reg - 1'b1);
                    state_next = S_LASTRD;
                end
                else
                    state_next = S_WAIT;
            end
            S_LASTRD:
            begin
                item_next = rd_reg;
                count_next = count_reg - 1'b1;
                pos_next = '0;
                state_next = S_DNRD;
            end
            S_DNRD:
            begin
                best_next = item_reg; pick_next = pos_reg;
                if (lidx < {1'b0, count_reg})
                begin
                    rd_addr = lidx[IDX_BITS-1:0];
                    side_next = 1'b0;
                    state_next = S_DNCMP;
                end
                else
                begin
                    we = 1'b1; wa = pos_reg; wd = item_reg;
                    if (pos_reg == '0) root_next = ex_of(item_reg);
                    state_next = S_EMIT;
                end
            end
            S_DNCMP:
            begin
                if (!(ex_of(rd_reg) > ex_of(best_reg)))
                begin
                    best_next = rd_reg;
                    pick_next = side_reg ? lidx[IDX_BITS-1:0] + 1'b1
                                         : lidx[IDX_BITS-1:0];
                end
                if (!side_reg && lidx + 1'b1 < {1'b0, count_reg})
                begin
                    rd_addr = lidx[IDX_BITS-1:0] + 1'b1;
                    side_next = 1'b1;
                end
                else
                begin
                    // right child is the old last slot, i.e. the entry being
                    // placed: a tie with the left child keeps the entry here
                    if (!side_reg && lidx + 1'b1 == {1'b0, count_reg} &&
                        !(ex_of(item_reg) > ex_of(best_next)))
                        pick_next = pos_reg;
                    state_next = S_DNRD2;
                end
            end
            S_DNRD2:
            begin
                if (pick_reg == pos_reg)
                begin
                    we = 1'b1; wa = pos_reg; wd = item_reg;
                    if (pos_reg == '0) root_next = ex_of(item_reg);
                    state_next = S_EMIT;
                end
                else
                begin
                    we = 1'b1; wa = pos_reg; wd = best_reg;
                    if (pos_reg == '0) root_next = ex_of(best_reg);
                    pos_next = pick_reg;
                    state_next = S_DNRD;
                end
            end
            S_EMIT:
            begin
                if (top_reg[0])
                begin
                    if (!ov_next)
                    begin
                        live_next[top_reg[TAG_BITS:1]] = 1'b0;
                        out_next.kind = KIND_FIRED;
                        out_next.fired_tag = top_reg[TAG_BITS:1];
                        out_next.last = 1'b0;
                        out_next.pending = count_reg != '0;
                        out_next.next_expiry = (count_reg != '0) ? root_reg : '0;
                        out_next.entry_total = count_reg;
                        ov_next = 1'b1;
                        state_next = S_ROOT;
                    end
                end
                else
                    state_next = S_ROOT;
            end
            S_WAIT:
            begin
                if (!ov_next)
                begin
                    // poll closes with its summary word
                    if (in_reg.command == CMD_POLL)
                    begin
                        out_next.kind = KIND_SUMMARY;
                        out_next.fired_tag = '0;
                        out_next.last = 1'b1;
                    end
                    out_next.pending = count_reg != '0;
                    out_next.next_expiry = (count_reg != '0) ? root_reg : '0;
                    out_next.entry_total = count_reg;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            live_reg  <= '0;
            ov_reg    <= 1'b0;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            live_reg  <= live_next;
            ov_reg    <= ov_next;
            side_reg  <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next; item_reg <= item_next; best_reg <= best_next;
        pick_reg <= pick_next; root_reg <= root_next; top_reg <= top_next;
        in_reg <= in_next; out_reg <= out_next;
    end

    // heap entry count never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(HEAP_DEPTH))
        else $error("heap count overflow");
    // no command accepted while a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> !cmd.ready)
        else $error("ready with result pending");
    // a held result stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid && $stable(res.data))
        else $error("result dropped");
endmodule
